[src/xild_pkg.sv]
package xild_pkg;

  localparam int unsigned MAX_LEN = 15;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned SEEN_W  = 5;

  localparam logic [7:0] OPC_ESCAPE  = 8'h0F;
  localparam logic [7:0] OPC_ESC3A   = 8'h3A;
  localparam logic [3:0] REX_HIGH    = 4'h4;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_OPCODE = 3'd1,
    PH_OPC2   = 3'd2,
    PH_ESC3   = 3'd3,
    PH_MODRM  = 3'd4,
    PH_SIB    = 3'd5,
    PH_TAIL   = 3'd6
  } phase_e;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       start_new;
  } item_t;

  typedef struct packed {
    logic       ok;
    logic       has_modrm;
    logic [3:0] imm;
  } opc_class_t;

  function automatic logic is_legacy_prefix(logic [7:0] b);
    logic r;
    case (b) inside
      8'h66, 8'h67, 8'hF0, 8'hF2, 8'hF3,
      8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic opc_class_t classify_one(logic [7:0] op);
    opc_class_t c;
    c = '0;
    c.ok = 1'b1;
    if ((op & 8'hC4) == 8'h00 && op[2:0] <= 3'd3 && op <= 8'h3B) begin
      c.has_modrm = 1'b1;
    end else if (op <= 8'h3D && op[2:0] == 3'd4) begin
      c.imm = 4'd1;
    end else if (op <= 8'h3D && op[2:0] == 3'd5) begin
      c.imm = 4'd4;
    end else if (op >= 8'h70 && op <= 8'h7F) begin
      c.imm = 4'd1;
    end else if (op >= 8'hB0 && op <= 8'hB7) begin
      c.imm = 4'd1;
    end else if (op >= 8'hB8) begin
      if (op <= 8'hBF) begin
        c.imm = 4'd8;
      end else begin
        case (op) inside
          8'hC0, 8'hC1, 8'hD0, 8'hD1, 8'hD2, 8'hD3,
          8'hF6, 8'hF7, 8'hFE, 8'hFF: c.has_modrm = 1'b1;
          8'hCD, 8'hD4, 8'hD5, 8'hE4, 8'hE5, 8'hE6, 8'hE7, 8'hEB: c.imm = 4'd1;
          8'hC7, 8'hE8, 8'hE9: c.imm = 4'd4;
          8'hC2, 8'hCA: begin
            c.has_modrm = 1'b1;
            c.imm       = 4'd1;
          end
          default: c.ok = 1'b0;
        endcase
      end
    end else if (op >= 8'h84 && op <= 8'h8B) begin
      c.has_modrm = 1'b1;
    end else begin
      case (op) inside
        8'h8D, 8'h8F, 8'h62, 8'h63: c.has_modrm = 1'b1;
        8'h6A, 8'hA8: c.imm = 4'd1;
        8'h68, 8'h69, 8'h81, 8'hA9, 8'hA0, 8'hA1, 8'hA2, 8'hA3: c.imm = 4'd4;
        8'h6B, 8'h80, 8'h82, 8'h83: begin
          c.has_modrm = 1'b1;
          c.imm       = 4'd1;
        end
        default: c.ok = 1'b0;
      endcase
    end
    return c;
  endfunction

  function automatic logic [3:0] imm_two(logic [7:0] op2);
    logic [3:0] r;
    case (op2) inside
      8'h70, 8'h71, 8'h72, 8'h73, 8'hA4, 8'hAC, 8'hBA,
      8'hC2, 8'hC4, 8'hC5, 8'hC6, 8'h3A: r = 4'd1;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] disp_bytes(logic [1:0] md, logic [2:0] low);
    logic [2:0] r;
    if (md == 2'd0 && low == 3'd5) begin
      r = 3'd4;
    end else if (md == 2'd1) begin
      r = 3'd1;
    end else if (md == 2'd2) begin
      r = 3'd4;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

endpackage

[src/xild_in_stage.sv]
module xild_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  xild_pkg::item_t item_i,
  output logic            item_valid_o,
  input  logic            item_ready_i,
  output xild_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  xild_pkg::item_t item_q;

  assign in_ready_o = !valid_q || item_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

[src/xild_core.sv]
module xild_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  input  xild_pkg::item_t item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [3:0]      instr_length_o
);

  xild_pkg::phase_e phase_q, phase_d, phase_n, phase_cur;
  logic [xild_pkg::SEEN_W-1:0] seen_q, seen_d, seen;
  logic [3:0] imm_q, imm_d, imm_n, imm_cur;
  logic [3:0] left_q, left_d, left_n, left_cur;
  logic [1:0] mod_q, mod_d, mod_n, mod_cur;
  logic       out_valid_q, out_valid_d;
  logic [3:0] len_q, len_d;
  logic       adv, done, bad, emit, overlong;
  logic [7:0] b;
  logic [3:0] tail_cnt;
  xild_pkg::opc_class_t cls;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign adv          = item_valid_i && item_ready_o;
  assign b            = item_i.code_byte;
  assign cls          = xild_pkg::classify_one(b);

  // Step one byte through the decode.
  always_comb begin
    phase_cur = item_i.start_new ? xild_pkg::PH_FIRST : phase_q;
    imm_cur   = item_i.start_new ? 4'd0 : imm_q;
    left_cur  = item_i.start_new ? 4'd0 : left_q;
    mod_cur   = item_i.start_new ? 2'd0 : mod_q;
    seen      = (item_i.start_new ? '0 : seen_q) + 1'b1;
    phase_n   = phase_cur;
    imm_n     = imm_cur;
    left_n    = left_cur;
    mod_n     = mod_cur;
    done      = 1'b0;
    bad       = 1'b0;
    tail_cnt  = 4'd0;
    unique case (phase_cur)
      xild_pkg::PH_FIRST, xild_pkg::PH_OPCODE: begin
        if (phase_cur == xild_pkg::PH_FIRST && xild_pkg::is_legacy_prefix(b)) begin
          phase_n = phase_cur;
        end else if (phase_cur == xild_pkg::PH_FIRST && b[7:4] == xild_pkg::REX_HIGH) begin
          phase_n = xild_pkg::PH_OPCODE;
        end else if (b == xild_pkg::OPC_ESCAPE) begin
          phase_n = xild_pkg::PH_OPC2;
        end else if (!cls.ok) begin
          bad = 1'b1;
        end else begin
          imm_n = cls.imm;
          if (cls.has_modrm) begin
            phase_n = xild_pkg::PH_MODRM;
          end else begin
            phase_n = xild_pkg::PH_TAIL;
            left_n  = cls.imm;
            done    = (cls.imm == 4'd0);
          end
        end
      end
      xild_pkg::PH_OPC2: begin
        imm_n   = xild_pkg::imm_two(b);
        phase_n = (b == xild_pkg::OPC_ESC3A) ? xild_pkg::PH_ESC3 : xild_pkg::PH_MODRM;
      end
      xild_pkg::PH_ESC3: begin
        phase_n = xild_pkg::PH_MODRM;
      end
      xild_pkg::PH_MODRM: begin
        mod_n = b[7:6];
        if (b[7:6] != 2'd3 && b[2:0] == 3'd4) begin
          phase_n = xild_pkg::PH_SIB;
        end else begin
          tail_cnt = {1'b0, xild_pkg::disp_bytes(b[7:6], b[2:0])} + imm_cur;
          phase_n  = xild_pkg::PH_TAIL;
          left_n   = tail_cnt;
          done     = (tail_cnt == 4'd0);
        end
      end
      xild_pkg::PH_SIB: begin
        tail_cnt = {1'b0, xild_pkg::disp_bytes(mod_cur, b[2:0])} + imm_cur;
        phase_n  = xild_pkg::PH_TAIL;
        left_n   = tail_cnt;
        done     = (tail_cnt == 4'd0);
      end
      default: begin
        left_n = left_cur - 4'd1;
        done   = (left_n == 4'd0);
      end
    endcase
  end

  assign overlong = seen > xild_pkg::SEEN_W'(xild_pkg::MAX_LEN);
  assign emit     = bad || overlong || done;

  // Next state.
  always_comb begin
    phase_d = phase_q;
    seen_d  = seen_q;
    imm_d   = imm_q;
    left_d  = left_q;
    mod_d   = mod_q;
    if (adv) begin
      if (emit) begin
        phase_d = xild_pkg::PH_FIRST;
        seen_d  = '0;
        imm_d   = 4'd0;
        left_d  = 4'd0;
        mod_d   = 2'd0;
      end else begin
        phase_d = phase_n;
        seen_d  = seen;
        imm_d   = imm_n;
        left_d  = left_n;
        mod_d   = mod_n;
      end
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    len_d       = len_q;
    if (adv) begin
      out_valid_d = emit;
      len_d       = (bad || overlong) ? 4'd0 : seen[xild_pkg::LEN_W-1:0];
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= xild_pkg::PH_FIRST;
      seen_q      <= '0;
      imm_q       <= 4'd0;
      left_q      <= 4'd0;
      mod_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      seen_q      <= seen_d;
      imm_q       <= imm_d;
      left_q      <= left_d;
      mod_q       <= mod_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
  end

  assign out_valid_o    = out_valid_q;
  assign instr_length_o = len_q;

  a_seen_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= xild_pkg::SEEN_W'(xild_pkg::MAX_LEN))
    else $error("byte count passed the length limit");

  a_tail_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == xild_pkg::PH_TAIL |-> left_q != 4'd0)
    else $error("tail phase with nothing left");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && emit |=> seen_q == '0 && phase_q == xild_pkg::PH_FIRST)
    else $error("state not cleared after result");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv && emit))
    else $error("result without a transfer");

endmodule

[src/x86_64_instruction_length_decoder.sv]
// x86-64 instruction length decoder.
// Input channel: one code byte per transfer (code_byte_i, start_new_i) under
// in_valid_i / in_ready_o. start_new_i drops any decode in progress and takes
// the byte as the first byte of a new instruction.
// Output channel: instr_length_o under out_valid_o / out_ready_i, one transfer
// on the last byte of each instruction; 0 marks an unsupported opcode or an
// instruction longer than 15 bytes, after which decoding restarts.
// Bytes that do not end an instruction give no output.
// Path: the last byte passes the input register, then the result register,
// before its result is offered.
// Throughput: one byte per cycle while no result waits on out_ready_i; each
// byte passes a table decode and a small add into the state registers.
// Reset: the decoder waits for the first byte of an instruction, both
// registers empty.
// Stall: while out_ready_i is low a pending result holds; the input register
// still takes one byte, then in_ready_o drops until the result is taken.
module x86_64_instruction_length_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] code_byte_i,
  input  logic       start_new_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] instr_length_o
);

  xild_pkg::item_t in_item, s1_item;
  logic            s1_valid, s1_ready;

  assign in_item.code_byte = code_byte_i;
  assign in_item.start_new = start_new_i;

  xild_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_item),
    .item_valid_o (s1_valid),
    .item_ready_i (s1_ready),
    .item_o       (s1_item)
  );

  xild_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (s1_valid),
    .item_ready_o   (s1_ready),
    .item_i         (s1_item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .instr_length_o (instr_length_o)
  );

endmodule
